// ===== design/spq_pkg.sv =====
// Package for the sorted priority queue.
// Holds shared constants, result status codes and the cell control type.
// No dependencies.
package spq_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Capacity register
    localparam int         CAP_W     = 5;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // Operation codes carried on the input tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ENQ_OK = 2'd0;
    localparam logic [1:0] ST_DEQ_OK = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;  // insert the broadcast value
        logic del;  // shift toward the head
    } t_cell_ctrl;

endpackage

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue, top level: chain of spq_cell storage slots, fill
// count, capacity register and registered result stage.
// Depends on spq_pkg and spq_cell.
//
// Values sit in a row of DEPTH cells sorted largest first, the head in cell
// 0; equal values leave in arrival order. Each input transaction (tuser 0
// enqueue, 1 dequeue) is applied to every cell at once: each cell compares
// its value with the new one and keeps, takes the new value or takes its
// neighbor's, so a new transaction can be accepted every cycle while the
// output side keeps up. Each transaction returns one registered result in
// the cycle after acceptance, with a status, the removed value (zero unless
// a dequeue succeeded) and the count afterward. The queue is full at
// min(capacity, DEPTH) entries; lowering capacity drops nothing. The user
// must write capacity through i_cfg_we/i_cfg_data while idle; not enforced.
module sorted_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // capacity register
    input  logic                      i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0] i_cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_W-1:0]           s_axis_tdata,   // value
    input  logic                      s_axis_tuser,   // func
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata,   // dequeued_value, occupancy
    output logic [1:0]                m_axis_tuser    // status
);

    localparam int CMP_W = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [spq_pkg::CAP_W-1:0] r_cap;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic [DATA_WIDTH-1:0]     r_deq;
    logic [DATA_WIDTH-1:0]     n_deq;
    logic [CNT_W-1:0]          r_occ;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic [DATA_WIDTH-1:0] w_value;
    spq_pkg::t_cell_ctrl   w_ctrl;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic                  w_ge   [DEPTH];

    assign w_value  = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Input side runs whenever the result register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    // Full at capacity or at the physical depth
    assign w_full  = (r_count == CNT_W'(DEPTH)) ||
                     (CMP_W'(r_count) >= CMP_W'(r_cap));
    assign w_empty = (r_count == '0);

    // Command and status decode
    always_comb begin
        w_ctrl.ins = 1'b0;
        w_ctrl.del = 1'b0;
        n_count    = r_count;
        n_deq      = '0;
        if (s_axis_tuser == spq_pkg::OP_ENQ) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_status   = spq_pkg::ST_ENQ_OK;
                w_ctrl.ins = w_accept;
                n_count    = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status   = spq_pkg::ST_DEQ_OK;
                w_ctrl.del = w_accept;
                n_count    = r_count - CNT_W'(1);
                n_deq      = w_data[0];
            end
        end
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_data;
        logic                  w_left_ge;
        logic [DATA_WIDTH-1:0] w_right_data;

        if (g == 0) begin : g_head
            assign w_left_data = w_value;
            assign w_left_ge   = 1'b1;
        end else begin : g_mid
            assign w_left_data = w_data[g-1];
            assign w_left_ge   = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data = w_data[g];
        end else begin : g_body
            assign w_right_data = w_data[g+1];
        end

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_value      (w_value),
            .i_left_data  (w_left_data),
            .i_left_ge    (w_left_ge),
            .i_right_data (w_right_data),
            .o_data       (w_data[g]),
            .o_ge         (w_ge[g])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= spq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_deq    <= n_deq;
            r_occ    <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_W'({r_occ, r_deq});

`ifndef ASSERT_OFF
    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    // An accepted enqueue that succeeds grows the count by one
    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status == spq_pkg::ST_ENQ_OK)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not grow count");

    // Dequeue on an empty queue reports empty and keeps count at zero
    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == spq_pkg::OP_DEQ && w_empty)
        |=> (m_axis_tuser == spq_pkg::ST_EMPTY && r_count == '0))
        else $error("empty dequeue misreported");

    // Reported occupancy tracks the internal count right after acceptance
    a_occ_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_occ == r_count))
        else $error("occupancy mismatch");

    // Head is never smaller than the second entry
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2))
        |-> ($signed(w_data[0]) >= $signed(w_data[1])))
        else $error("head out of order");
`endif

endmodule

// ===== design/spq_cell.sv =====
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg (t_cell_ctrl).
module spq_cell #(
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_ctrl    i_ctrl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_left_data,   // neighbor toward the head
    input  logic                   i_left_ge,     // neighbor keeps its place
    input  logic [DATA_WIDTH-1:0]  i_right_data,  // neighbor toward the tail
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_ge
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_occ;

    // Occupied when this slot lies below the fill count
    assign w_occ = i_count > CNT_W'(IDX);

    // Stored value stays ahead of the new one when greater or equal
    assign o_ge   = w_occ && ($signed(r_data) >= $signed(i_value));
    assign o_data = r_data;

    // Insert: keep, take the new value, or take the left neighbor's value.
    // Remove: take the right neighbor's value.
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (!o_ge) begin
                n_data = i_left_ge ? i_value : i_left_data;
            end
        end else if (i_ctrl.del) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== test/sorted_priority_queue_tb.sv =====
// Testbench for sorted_priority_queue: directed table, then random enqueue/dequeue phases
// across capacity settings, checked against a behavioral sorted-list model.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

    localparam int QDEPTH     = spq_pkg::DEPTH_DEF;
    localparam int IN_BITS    = 32;
    localparam int OUT_BITS   = 40;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORT = 10;

    // One result transaction, unpacked
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] deq_val;
        logic [4:0]  occ;
    } t_spq_result;

    typedef enum logic {ROW_OP, ROW_CAP} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        func;
        logic [31:0] val;
        logic [4:0]  cap;
        logic        pinned;    // expected result typed in below
        t_spq_result want;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [spq_pkg::CAP_W-1:0] i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_BITS-1:0]        s_axis_tdata;   // value
    logic                      s_axis_tuser;   // func
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_BITS-1:0]       m_axis_tdata;   // dequeued_value, occupancy
    logic [1:0]                m_axis_tuser;   // status

    // Side-band that travels with each driven transaction
    logic                drv_pinned;
    t_spq_result         drv_pin_res;

    // Model state and scoreboard
    logic signed [31:0]        held_vals[$];
    logic [spq_pkg::CAP_W-1:0] cap_shadow = spq_pkg::CAP_RESET;
    t_spq_result               pending_results[$];
    int unsigned               mismatches = 0;
    bit                        steady = 1'b0;
    int unsigned               hold_len = 0;
    int unsigned               hold_req_id = 0;
    int unsigned               hold_done_id = 0;

    // Capacity used by each random phase
    logic [spq_pkg::CAP_W-1:0] phase_caps [0:9] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2,
                                                    5'd17, 5'd5, 5'd16, 5'd8, 5'd31};

    sorted_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Directed table: reset state, extremes, full/empty, capacity corners
    t_dir_row dir_rows [0:23] = '{
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b1,
          '{spq_pkg::ST_EMPTY,  32'h0,         5'd0}},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'h7FFF_FFFF, 5'd0,  1'b1,
          '{spq_pkg::ST_ENQ_OK, 32'h0,         5'd1}},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'h8000_0000, 5'd0,  1'b1,
          '{spq_pkg::ST_ENQ_OK, 32'h0,         5'd2}},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'h0,         5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'hFFFF_FFFF, 5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'h0,         5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'hFFFF_FFFF, 5'd0,  1'b1,
          '{spq_pkg::ST_DEQ_OK, 32'h7FFF_FFFF, 5'd4}},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h1234_5678, 5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b1,
          '{spq_pkg::ST_DEQ_OK, 32'h8000_0000, 5'd0}},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b1,
          '{spq_pkg::ST_EMPTY,  32'h0,         5'd0}},
        '{ROW_CAP, spq_pkg::OP_ENQ, 32'h0,         5'd1,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'd55,        5'd0,  1'b1,
          '{spq_pkg::ST_ENQ_OK, 32'h0,         5'd1}},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'd66,        5'd0,  1'b1,
          '{spq_pkg::ST_FULL,   32'h0,         5'd1}},
        '{ROW_CAP, spq_pkg::OP_ENQ, 32'h0,         5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'd1,         5'd0,  1'b1,
          '{spq_pkg::ST_FULL,   32'h0,         5'd1}},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b1,
          '{spq_pkg::ST_DEQ_OK, 32'd55,        5'd0}},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'd2,         5'd0,  1'b1,
          '{spq_pkg::ST_FULL,   32'h0,         5'd0}},
        '{ROW_CAP, spq_pkg::OP_ENQ, 32'h0,         5'd31, 1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'h5A5A_5A5A, 5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_ENQ, 32'hA5A5_A5A5, 5'd0,  1'b0, '0},
        '{ROW_OP,  spq_pkg::OP_DEQ, 32'h0,         5'd0,  1'b0, '0},
        '{ROW_CAP, spq_pkg::OP_ENQ, 32'h0,         5'd16, 1'b0, '0}
    };

    // Sorted-list model: largest first, equal values keep arrival order
    function automatic t_spq_result apply_op(logic func, logic signed [31:0] v);
        t_spq_result res;
        int          limit;
        int          pos;
        limit = (cap_shadow < QDEPTH) ? cap_shadow : QDEPTH;
        res   = '0;
        if (func == spq_pkg::OP_ENQ) begin
            if (held_vals.size() >= limit) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_vals.size() && held_vals[pos] >= v) pos++;
                held_vals.insert(pos, v);
                res.status = spq_pkg::ST_ENQ_OK;
            end
        end else if (held_vals.size() == 0) begin
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            res.deq_val = held_vals.pop_front();
            res.status  = spq_pkg::ST_DEQ_OK;
        end
        res.occ = 5'(held_vals.size());
        return res;
    endfunction

    // Mostly short gaps, now and then a long one; none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 45) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Extremes, a narrow band around zero for ties, else full range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return 32'($urandom_range(6)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    task automatic note_failure(string what, t_spq_result want, t_spq_result got);
        mismatches++;
        if (mismatches <= MAX_REPORT)
            $display({"%0t: %s: expected status %0d value %h occ %0d, ",
                      "got status %0d value %h occ %0d"},
                     $realtime, what, want.status, want.deq_val, want.occ,
                     got.status, got.deq_val, got.occ);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic push_op(input logic func, input logic [31:0] v, input logic pin,
                           input t_spq_result pin_res);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= v;
        drv_pinned    <= pin;
        drv_pin_res   <= pin_res;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [spq_pkg::CAP_W-1:0] cap);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Fill toward enq_pct first, then drain with the opposite bias
    task automatic run_phase(input logic [spq_pkg::CAP_W-1:0] cap, input int unsigned n,
                             input int unsigned enq_pct);
        int unsigned pct;
        logic        func;
        write_capacity(cap);
        for (int unsigned i = 0; i < n; i++) begin
            pct  = (i < n / 2) ? enq_pct : 100 - enq_pct;
            func = ($urandom_range(99) < pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
            push_op(func, pick_value(), 1'b0, '0);
        end
    endtask

    // Scoreboard: predict on input acceptance, compare on output acceptance
    always @(posedge i_clk) begin : scoreboard
        t_spq_result pred;
        t_spq_result want;
        t_spq_result got;
        if (i_rst_n) begin
            if (i_cfg_we) cap_shadow = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                pred = apply_op(s_axis_tuser, s_axis_tdata);
                pending_results.push_back(drv_pinned ? drv_pin_res : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]};
                if (pending_results.size() == 0) begin
                    note_failure("result with nothing pending", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status || got.deq_val != want.deq_val ||
                        got.occ != want.occ)
                        note_failure("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        int unsigned idle_cycles;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result sink: random ready, plus a long hold-off on request while the
    // source is offering
    initial begin : result_sink
        int unsigned run_len;
        int unsigned gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req_id != hold_done_id && s_axis_tvalid) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_done_id = hold_req_id;
            end
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(1, 20);
            repeat (run_len) @(posedge i_clk);
            gap = pick_gap();
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= spq_pkg::OP_ENQ;
        drv_pinned    <= 1'b0;
        drv_pin_res   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CAP)
                write_capacity(dir_rows[i].cap);
            else
                push_op(dir_rows[i].func, dir_rows[i].val, dir_rows[i].pinned,
                        dir_rows[i].want);
        end

        foreach (phase_caps[p]) begin
            // back pressure: sink stalls while the source streams without gaps
            if (p == 7) begin
                hold_len = 100;
                hold_req_id++;
                steady = 1'b1;
            end else begin
                steady = (p == 4);
            end
            run_phase(phase_caps[p], (phase_caps[p] == 0) ? 30 : 80,
                      $urandom_range(55, 85));
        end
        steady = 1'b0;

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
